>>> hdl/dual_ultrasonic_ranger_angle_unit_defines.svh
// Assertion macros used by the ranger top-level RTL file.
`ifndef DUAL_ULTRASONIC_RANGER_ANGLE_UNIT_DEFINES_SVH
`define DUAL_ULTRASONIC_RANGER_ANGLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define DURA_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define DURA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DURA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DURA_ASSERT_HOLDS(lbl, cond, msg)
`define DURA_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define DURA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/dura_pkg.sv
// Types, constants and the arctangent table of the dual ultrasonic ranger.
`timescale 1ns / 1ps

package dura_pkg;

    localparam int WIDTH_BITS   = 16;
    localparam int CORDIC_STEPS = 14;
    localparam int ATAN_LEN     = 20;
    localparam int CORDIC_FRAC  = 8;
    localparam int STEP_COUNT   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    localparam int PERIOD_W  = 20;
    localparam int TRIG_W    = 8;
    localparam int RANGE_W   = 15;
    localparam int MARGIN_W  = 11;
    localparam int SPACING_W = 12;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    localparam int DIST_W  = 16;
    localparam int ANGLE_W = 14;
    localparam int DY_W    = DIST_W + 1;

    localparam int RANGE_DIV  = 58;
    localparam int DIV_HALF   = RANGE_DIV / 2;
    localparam int ROUND_HALF = RANGE_DIV / 4;
    localparam int MW         = WIDTH_BITS + 5;
    localparam int RW         = MW - 4;
    localparam int QW         = WIDTH_BITS + 1;
    localparam int CMP_W      = (WIDTH_BITS + 6 > RANGE_W + 6) ? WIDTH_BITS + 6 : RANGE_W + 6;
    localparam int SW         = (WIDTH_BITS + 3 > DY_W) ? WIDTH_BITS + 3 : DY_W;
    localparam longint RECIP_L = (longint'(1) << MW) / DIV_HALF;

    localparam int CW           = DY_W + CORDIC_FRAC + 2;
    localparam int ZW           = 25;
    localparam int ANGLE_SHIFT  = 10;
    localparam int ANGLE_HALF   = 1 << (ANGLE_SHIFT - 1);
    localparam int ANGLE_LIMIT  = 5760;
    localparam int CORDIC_LAT   = STEP_COUNT + 1;

    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;
    localparam int IN_DATA_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE     = 3'd0,
        REG_PERIOD_US  = 3'd1,
        REG_TRIGGER_US = 3'd2,
        REG_MAX_RANGE  = 3'd3,
        REG_MARGIN_ONE = 3'd4,
        REG_MARGIN_TWO = 3'd5,
        REG_SPACING    = 3'd6
    } cfg_reg_t;

    localparam logic [PERIOD_W-1:0]         PERIOD_RST     = 20'd100000;
    localparam logic [TRIG_W-1:0]           TRIGGER_RST    = 8'd10;
    localparam logic [RANGE_W-1:0]          MAX_RANGE_RST  = 15'd1600;
    localparam logic signed [MARGIN_W-1:0]  MARGIN_ONE_RST = -11'sd83;
    localparam logic signed [MARGIN_W-1:0]  MARGIN_TWO_RST = -11'sd32;
    localparam logic [SPACING_W-1:0]        SPACING_RST    = 12'd326;

    typedef struct packed {
        logic level;
        logic valid_one;
        logic valid_two;
    } side_t;

    // atan(2^-i) in 1/65536 degree.
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] a;
        a = '0;
        case (i)
            0:  a = 25'sd2949120;
            1:  a = 25'sd1740967;
            2:  a = 25'sd919879;
            3:  a = 25'sd466945;
            4:  a = 25'sd234379;
            5:  a = 25'sd117304;
            6:  a = 25'sd58666;
            7:  a = 25'sd29335;
            8:  a = 25'sd14668;
            9:  a = 25'sd7334;
            10: a = 25'sd3667;
            11: a = 25'sd1833;
            12: a = 25'sd917;
            13: a = 25'sd458;
            14: a = 25'sd229;
            15: a = 25'sd115;
            16: a = 25'sd57;
            17: a = 25'sd29;
            18: a = 25'sd14;
            19: a = 25'sd7;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> hdl/dura_range.sv
// Two-stage pulse-width to distance conversion with clamp, margin and saturation.
`timescale 1ns / 1ps

module dura_range
    import dura_pkg::*;
(
    input  logic                        clk,
    input  logic                        adv,
    input  logic [WIDTH_BITS-1:0]       width,
    input  logic                        width_valid,
    input  logic [RANGE_W-1:0]          range_limit,
    input  logic signed [MARGIN_W-1:0]  margin,
    output logic signed [DIST_W-1:0]    distance
);

    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
    localparam logic signed [SW-1:0] DIST_HI = SW'((1 << (DIST_W - 1)) - 1);
    localparam logic signed [SW-1:0] DIST_LO = -SW'(1 << (DIST_W - 1));

    logic [CMP_W-1:0]      w64;
    logic [CMP_W-1:0]      lim;
    logic [MW-1:0]         m;
    logic [MW+RW-1:0]      prod;

    logic                  over_reg;
    logic                  valid_reg;
    logic [MW-1:0]         m_reg;
    logic [QW-1:0]         q_est_reg;

    logic [MW:0]           qm;
    logic [MW:0]           rem;
    logic [QW-1:0]         q;
    logic signed [SW-1:0]  sum;
    logic signed [SW-1:0]  dsel;
    logic signed [DIST_W-1:0] dist_next;
    logic signed [DIST_W-1:0] dist_reg;

    // The width maps to round(64 * w / 58) = floor((32 * w + 14) / 29).
    assign w64  = CMP_W'({width, 6'b0});
    assign lim  = CMP_W'(range_limit) * CMP_W'(RANGE_DIV);
    assign m    = MW'({width, 5'b0}) + MW'(ROUND_HALF);
    assign prod = (MW+RW)'(m) * (MW+RW)'(RECIP);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            over_reg  <= (w64 > lim);
            valid_reg <= width_valid;
            m_reg     <= m;
            q_est_reg <= prod[MW +: QW];
        end
    end

    // The reciprocal estimate is low by at most one.
    always_comb
    begin
        qm   = (MW+1)'(q_est_reg) * (MW+1)'(DIV_HALF);
        rem  = (MW+1)'(m_reg) - qm;
        q    = q_est_reg + QW'(rem >= (MW+1)'(DIV_HALF));
        sum  = signed'(SW'(q)) + SW'(margin);
        dsel = over_reg ? signed'(SW'(range_limit)) : sum;
        if (!valid_reg)
        begin
            dist_next = '0;
        end
        else if (dsel > DIST_HI)
        begin
            dist_next = DIST_HI[DIST_W-1:0];
        end
        else if (dsel < DIST_LO)
        begin
            dist_next = DIST_LO[DIST_W-1:0];
        end
        else
        begin
            dist_next = dsel[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg <= dist_next;
        end
    end

    assign distance = dist_reg;

endmodule

>>> hdl/dura_cordic.sv
// Pipelined vectoring CORDIC that accumulates atan2(dy, spacing) in 1/65536 degree.
`timescale 1ns / 1ps

module dura_cordic
    import dura_pkg::*;
(
    input  logic                        clk,
    input  logic                        adv,
    input  logic signed [DY_W-1:0]      dy,
    input  logic [SPACING_W-1:0]        spacing,
    output logic signed [ZW-1:0]        z_out
);

    logic signed [CW-1:0] x_reg [0:STEP_COUNT];
    logic signed [CW-1:0] y_reg [0:STEP_COUNT];
    logic signed [ZW-1:0] z_reg [0:STEP_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= {{(CW-SPACING_W-CORDIC_FRAC){1'b0}}, spacing, {CORDIC_FRAC{1'b0}}};
            y_reg[0] <= {{(CW-DY_W-CORDIC_FRAC){dy[DY_W-1]}}, dy, {CORDIC_FRAC{1'b0}}};
            z_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < STEP_COUNT; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] ATAN_I = atan_entry(i);

        logic signed [CW-1:0] x_sh;
        logic signed [CW-1:0] y_sh;
        logic                 y_pos;
        logic                 y_neg;

        assign x_sh  = x_reg[i] >>> i;
        assign y_sh  = y_reg[i] >>> i;
        assign y_neg = y_reg[i][CW-1];
        assign y_pos = !y_neg && (y_reg[i] != '0);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (y_pos)
                begin
                    x_reg[i+1] <= x_reg[i] + y_sh;
                    y_reg[i+1] <= y_reg[i] - x_sh;
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
                else if (y_neg)
                begin
                    x_reg[i+1] <= x_reg[i] - y_sh;
                    y_reg[i+1] <= y_reg[i] + x_sh;
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end
            end
        end
    end

    assign z_out = z_reg[STEP_COUNT];

endmodule

>>> hdl/dual_ultrasonic_ranger_angle_unit.sv
// Top level of the dual ultrasonic ranger with trigger timing, echo capture and angle.
// A tick beat passes the echo capture, the two range stages, the CORDIC and the output register.
// Throughput: one tick beat per cycle; the CORDIC runs one iteration per pipeline stage.
// A stall on the output side holds the whole pipeline and drops s_axis_tready.
// Reset clears the timing counters, echo state, captured widths and valid flags, and loads
// the register defaults; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`include "dual_ultrasonic_ranger_angle_unit_defines.svh"

module dual_ultrasonic_ranger_angle_unit
    import dura_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // Fields from bit 0: echo_one, echo_two, zero fill.
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,

    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // Fields from bit 0: trigger_level, dist_one, dist_two, angle, zero fill.
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // Fields from bit 0: valid_one, valid_two.
    output logic [OUT_USER_W-1:0]   m_axis_tuser,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int NV = 3 + CORDIC_LAT;
    localparam logic signed [ZW:0] ANG_HI = (ZW+1)'(ANGLE_LIMIT);
    localparam logic signed [ZW:0] ANG_LO = -(ZW+1)'(ANGLE_LIMIT);

    logic                         enable_reg;
    logic [PERIOD_W-1:0]          period_us_reg;
    logic [TRIG_W-1:0]            trigger_us_reg;
    logic [RANGE_W-1:0]           range_limit_reg;
    logic signed [MARGIN_W-1:0]   margin_one_reg;
    logic signed [MARGIN_W-1:0]   margin_two_reg;
    logic [SPACING_W-1:0]         spacing_reg;

    logic [PERIOD_W-1:0]          period_count_reg, period_count_next;
    logic [TRIG_W-1:0]            pulse_count_reg, pulse_count_next;
    logic                         trigger_on_reg, trigger_on_next;
    logic                         level_reg, level_next;
    logic [1:0]                   prev_echo_reg, prev_echo_next;
    logic [WIDTH_BITS-1:0]        width_running_reg [0:1];
    logic [WIDTH_BITS-1:0]        width_running_next [0:1];
    logic [WIDTH_BITS-1:0]        width_captured_reg [0:1];
    logic [WIDTH_BITS-1:0]        width_captured_next [0:1];
    logic [1:0]                   captured_valid_reg, captured_valid_next;

    logic                         adv;
    logic                         accept;
    logic [NV-1:0]                vld_reg;
    logic                         m_valid_reg;
    logic [OUT_DATA_W-1:0]        m_data_reg;
    logic [OUT_USER_W-1:0]        m_user_reg;

    side_t                        side_reg [1:NV-1];
    side_t                        side_head;
    logic signed [DIST_W-1:0]     dist_one_pipe [3:NV-1];
    logic signed [DIST_W-1:0]     dist_two_pipe [3:NV-1];
    logic signed [DIST_W-1:0]     dist_one;
    logic signed [DIST_W-1:0]     dist_two;
    logic signed [ZW-1:0]         z_out;

    logic signed [ZW:0]           z_round;
    logic signed [ZW:0]           z_scaled;
    logic signed [ANGLE_W-1:0]    angle_next;
    side_t                        side_tail;

    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            period_us_reg   <= PERIOD_RST;
            trigger_us_reg  <= TRIGGER_RST;
            range_limit_reg <= MAX_RANGE_RST;
            margin_one_reg  <= MARGIN_ONE_RST;
            margin_two_reg  <= MARGIN_TWO_RST;
            spacing_reg     <= SPACING_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLE:     enable_reg      <= cfg_data[0];
                REG_PERIOD_US:  period_us_reg   <= cfg_data[PERIOD_W-1:0];
                REG_TRIGGER_US: trigger_us_reg  <= cfg_data[TRIG_W-1:0];
                REG_MAX_RANGE:  range_limit_reg <= cfg_data[RANGE_W-1:0];
                REG_MARGIN_ONE: margin_one_reg  <= signed'(cfg_data[MARGIN_W-1:0]);
                REG_MARGIN_TWO: margin_two_reg  <= signed'(cfg_data[MARGIN_W-1:0]);
                REG_SPACING:    spacing_reg     <= cfg_data[SPACING_W-1:0];
                default: ;
            endcase
        end
    end

    // Echo edges are taken first, then the trigger timing advances by one tick.
    always_comb
    begin
        logic [TRIG_W:0]     pc;
        logic [TRIG_W:0]     plen;
        logic [PERIOD_W:0]   pcnt;
        logic [PERIOD_W:0]   per;
        logic                tr;
        logic                e;

        for (int c = 0; c < 2; c++)
        begin
            e = s_axis_tdata[c];
            width_running_next[c]  = width_running_reg[c];
            width_captured_next[c] = width_captured_reg[c];
            captured_valid_next[c] = captured_valid_reg[c];
            if (e && !prev_echo_reg[c])
            begin
                width_running_next[c] = WIDTH_BITS'(1);
            end
            else if (e)
            begin
                if (width_running_reg[c] != '1)
                begin
                    width_running_next[c] = width_running_reg[c] + WIDTH_BITS'(1);
                end
            end
            else if (prev_echo_reg[c])
            begin
                width_captured_next[c] = width_running_reg[c];
                captured_valid_next[c] = 1'b1;
            end
            prev_echo_next[c] = e;
        end

        plen = (trigger_us_reg == '0) ? (TRIG_W+1)'(1) : (TRIG_W+1)'(trigger_us_reg);
        per  = (period_us_reg == '0) ? (PERIOD_W+1)'(1) : (PERIOD_W+1)'(period_us_reg);
        tr   = trigger_on_reg;
        pc   = (TRIG_W+1)'(pulse_count_reg);
        pcnt = (PERIOD_W+1)'(period_count_reg);

        if (!enable_reg)
        begin
            level_next        = 1'b0;
            trigger_on_next   = 1'b0;
            pulse_count_next  = '0;
            period_count_next = '0;
        end
        else
        begin
            if (period_count_reg == '0)
            begin
                tr = 1'b1;
                pc = '0;
            end
            level_next = tr;
            if (tr)
            begin
                pc = pc + (TRIG_W+1)'(1);
                if (pc >= plen)
                begin
                    tr = 1'b0;
                    pc = '0;
                end
            end
            pcnt = pcnt + (PERIOD_W+1)'(1);
            if (pcnt >= per)
            begin
                pcnt = '0;
            end
            trigger_on_next   = tr;
            pulse_count_next  = pc[TRIG_W-1:0];
            period_count_next = pcnt[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg   <= '0;
            pulse_count_reg    <= '0;
            trigger_on_reg     <= 1'b0;
            level_reg          <= 1'b0;
            prev_echo_reg      <= '0;
            captured_valid_reg <= '0;
            for (int c = 0; c < 2; c++)
            begin
                width_running_reg[c]  <= '0;
                width_captured_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            period_count_reg   <= period_count_next;
            pulse_count_reg    <= pulse_count_next;
            trigger_on_reg     <= trigger_on_next;
            level_reg          <= level_next;
            prev_echo_reg      <= prev_echo_next;
            captured_valid_reg <= captured_valid_next;
            for (int c = 0; c < 2; c++)
            begin
                width_running_reg[c]  <= width_running_next[c];
                width_captured_reg[c] <= width_captured_next[c];
            end
        end
    end

    dura_range u_range_one (
        .clk         (clk),
        .adv         (adv),
        .width       (width_captured_reg[0]),
        .width_valid (captured_valid_reg[0]),
        .range_limit (range_limit_reg),
        .margin      (margin_one_reg),
        .distance    (dist_one)
    );

    dura_range u_range_two (
        .clk         (clk),
        .adv         (adv),
        .width       (width_captured_reg[1]),
        .width_valid (captured_valid_reg[1]),
        .range_limit (range_limit_reg),
        .margin      (margin_two_reg),
        .distance    (dist_two)
    );

    dura_cordic u_cordic (
        .clk     (clk),
        .adv     (adv),
        .dy      (DY_W'(dist_one) - DY_W'(dist_two)),
        .spacing (spacing_reg),
        .z_out   (z_out)
    );

    assign side_head = '{level: level_reg, valid_one: captured_valid_reg[0],
                         valid_two: captured_valid_reg[1]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1] <= side_head;
            for (int k = 2; k < NV; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            dist_one_pipe[3] <= dist_one;
            dist_two_pipe[3] <= dist_two;
            for (int k = 4; k < NV; k++)
            begin
                dist_one_pipe[k] <= dist_one_pipe[k-1];
                dist_two_pipe[k] <= dist_two_pipe[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NV-2:0], accept};
            m_valid_reg <= vld_reg[NV-1];
        end
    end

    // Round half up to 1/64 degree and clamp; no angle unless both channels hold a width.
    always_comb
    begin
        side_tail = side_reg[NV-1];
        z_round   = (ZW+1)'(z_out) + (ZW+1)'(ANGLE_HALF);
        z_scaled  = z_round >>> ANGLE_SHIFT;
        if (!(side_tail.valid_one && side_tail.valid_two))
        begin
            angle_next = '0;
        end
        else if (z_scaled > ANG_HI)
        begin
            angle_next = ANG_HI[ANGLE_W-1:0];
        end
        else if (z_scaled < ANG_LO)
        begin
            angle_next = ANG_LO[ANGLE_W-1:0];
        end
        else
        begin
            angle_next = z_scaled[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= {1'b0, angle_next, dist_two_pipe[NV-1], dist_one_pipe[NV-1],
                           side_tail.level};
            m_user_reg <= {side_tail.valid_two, side_tail.valid_one};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `DURA_ASSERT_NEXT(a_trig_off, accept && !enable_reg, !level_reg, "trigger while disabled")
    `DURA_ASSERT_IMPLIES(a_width_one, prev_echo_reg[0], width_running_reg[0] != '0, "width lost")
    `DURA_ASSERT_IMPLIES(a_width_two, prev_echo_reg[1], width_running_reg[1] != '0, "width lost")
    `DURA_ASSERT_NEXT(a_valid_sticky, &captured_valid_reg, &captured_valid_reg, "flag dropped")
    `DURA_ASSERT_IMPLIES(a_angle_both, m_axis_tvalid && !(&m_axis_tuser), m_axis_tdata[46:33] == '0, "angle")

endmodule

>>> dv/dual_ultrasonic_ranger_angle_unit_test.sv
// Self-checking testbench for the dual ultrasonic ranger angle unit.
`timescale 1ns / 1ps

module dual_ultrasonic_ranger_angle_unit_test;
    import dura_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int PIPE_DEPTH     = CORDIC_STEPS + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_TICKS    = 92;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;

    typedef struct {
        logic                       enable;
        logic [PERIOD_W-1:0]        period_us;
        logic [TRIG_W-1:0]          trigger_us;
        logic [RANGE_W-1:0]         range_limit;
        logic signed [MARGIN_W-1:0] margin_one;
        logic signed [MARGIN_W-1:0] margin_two;
        logic [SPACING_W-1:0]       spacing;
    } ranger_cfg_t;

    typedef struct {
        logic                      level;
        logic signed [DIST_W-1:0]  dist_one;
        logic signed [DIST_W-1:0]  dist_two;
        logic signed [ANGLE_W-1:0] angle;
        logic                      valid_one;
        logic                      valid_two;
    } ranger_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    ranger_cfg_t           cur_cfg;
    int unsigned           period_count;
    int unsigned           pulse_count;
    logic                  trigger_on;
    logic [1:0]            prev_echo;
    logic [WIDTH_BITS-1:0] width_running [2];
    logic [WIDTH_BITS-1:0] width_captured [2];
    logic [1:0]            captured_valid;
    ranger_beat_t          pending_ranges [$];
    int                    mismatch_count = 0;
    int                    stall_cycles = 0;
    bit                    idle_on = 1'b1;

    dual_ultrasonic_ranger_angle_unit u_top (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic ranger_cfg_t reset_cfg();
        ranger_cfg_t c;
        c.enable      = 1'b0;
        c.period_us   = PERIOD_RST;
        c.trigger_us  = TRIGGER_RST;
        c.range_limit = MAX_RANGE_RST;
        c.margin_one  = MARGIN_ONE_RST;
        c.margin_two  = MARGIN_TWO_RST;
        c.spacing     = SPACING_RST;
        return c;
    endfunction

    function automatic longint atan_step(input int i);
        case (i)
            0:  return 2949120;
            1:  return 1740967;
            2:  return 919879;
            3:  return 466945;
            4:  return 234379;
            5:  return 117304;
            6:  return 58666;
            7:  return 29335;
            8:  return 14668;
            9:  return 7334;
            10: return 3667;
            11: return 1833;
            12: return 917;
            13: return 458;
            14: return 229;
            15: return 115;
            16: return 57;
            17: return 29;
            18: return 14;
            19: return 7;
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [DIST_W-1:0] distance_of(
        input logic [WIDTH_BITS-1:0]     w,
        input logic signed [MARGIN_W-1:0] margin
    );
        longint d;
        if (longint'(w) * 64 > longint'(cur_cfg.range_limit) * RANGE_DIV)
            d = longint'(cur_cfg.range_limit);
        else
            d = (longint'(w) * 64 + DIV_HALF) / RANGE_DIV + longint'(margin);
        if (d > 32767)
            d = 32767;
        if (d < -32768)
            d = -32768;
        return d[DIST_W-1:0];
    endfunction

    function automatic logic signed [ANGLE_W-1:0] bearing_of(input longint dy, input longint dx);
        longint x;
        longint y;
        longint z;
        longint xo;
        longint a;
        x = dx * (longint'(1) << CORDIC_FRAC);
        y = dy * (longint'(1) << CORDIC_FRAC);
        z = 0;
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++)
        begin
            xo = x;
            if (y > 0)
            begin
                x = x + (y >>> i);
                y = y - (xo >>> i);
                z = z + atan_step(i);
            end
            else if (y < 0)
            begin
                x = x - (y >>> i);
                y = y + (xo >>> i);
                z = z - atan_step(i);
            end
        end
        a = (z + ANGLE_HALF) >>> ANGLE_SHIFT;
        if (a > ANGLE_LIMIT)
            a = ANGLE_LIMIT;
        if (a < -ANGLE_LIMIT)
            a = -ANGLE_LIMIT;
        return a[ANGLE_W-1:0];
    endfunction

    // Echo edges are handled before the trigger timing, as in the block.
    function automatic ranger_beat_t advance_ranger(input logic [1:0] echo);
        ranger_beat_t r;
        int unsigned  plen;
        int unsigned  per;
        r.level = 1'b0;
        r.angle = '0;
        for (int c = 0; c < 2; c++)
        begin
            if (echo[c] && !prev_echo[c])
                width_running[c] = WIDTH_BITS'(1);
            else if (echo[c])
            begin
                if (width_running[c] != WIDTH_MAX)
                    width_running[c]++;
            end
            else if (prev_echo[c])
            begin
                width_captured[c] = width_running[c];
                captured_valid[c] = 1'b1;
            end
        end
        prev_echo = echo;

        if (!cur_cfg.enable)
        begin
            period_count = 0;
            pulse_count  = 0;
            trigger_on   = 1'b0;
        end
        else
        begin
            plen = (cur_cfg.trigger_us != 0) ? cur_cfg.trigger_us : 1;
            per  = (cur_cfg.period_us != 0) ? cur_cfg.period_us : 1;
            if (period_count == 0)
            begin
                trigger_on  = 1'b1;
                pulse_count = 0;
            end
            r.level = trigger_on;
            if (trigger_on)
            begin
                pulse_count++;
                if (pulse_count >= plen)
                begin
                    trigger_on  = 1'b0;
                    pulse_count = 0;
                end
            end
            period_count++;
            if (period_count >= per)
                period_count = 0;
        end

        r.valid_one = captured_valid[0];
        r.valid_two = captured_valid[1];
        r.dist_one  = captured_valid[0] ? distance_of(width_captured[0], cur_cfg.margin_one) : '0;
        r.dist_two  = captured_valid[1] ? distance_of(width_captured[1], cur_cfg.margin_two) : '0;
        if (&captured_valid)
            r.angle = bearing_of(longint'(r.dist_one) - longint'(r.dist_two),
                                 longint'(cur_cfg.spacing));
        return r;
    endfunction

    function automatic void flag_mismatch(
        input string              field,
        input logic signed [31:0] want,
        input logic signed [31:0] got
    );
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t on %s: expected %0d, got %0d", $time, field, want, got);
    endfunction

    task automatic send_tick(input logic [1:0] echo);
        while (idle_on && $urandom_range(99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-2){1'b0}}, echo};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_ranges.push_back(advance_ranger(echo));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            REG_ENABLE:     cur_cfg.enable      = value[0];
            REG_PERIOD_US:  cur_cfg.period_us   = value[PERIOD_W-1:0];
            REG_TRIGGER_US: cur_cfg.trigger_us  = value[TRIG_W-1:0];
            REG_MAX_RANGE:  cur_cfg.range_limit = value[RANGE_W-1:0];
            REG_MARGIN_ONE: cur_cfg.margin_one  = value[MARGIN_W-1:0];
            REG_MARGIN_TWO: cur_cfg.margin_two  = value[MARGIN_W-1:0];
            REG_SPACING:    cur_cfg.spacing     = value[SPACING_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input ranger_cfg_t c);
        settle();
        write_reg(REG_UNUSED, CFG_W'($urandom));
        write_reg(REG_ENABLE, CFG_W'(c.enable));
        write_reg(REG_PERIOD_US, CFG_W'(c.period_us));
        write_reg(REG_TRIGGER_US, CFG_W'(c.trigger_us));
        write_reg(REG_MAX_RANGE, CFG_W'(c.range_limit));
        write_reg(REG_MARGIN_ONE, CFG_W'(c.margin_one));
        write_reg(REG_MARGIN_TWO, CFG_W'(c.margin_two));
        write_reg(REG_SPACING, CFG_W'(c.spacing));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_tick(2'b00);
        send_tick(2'b01);
        send_tick(2'b11);
        send_tick(2'b10);
        send_tick(2'b00);
    endtask

    task automatic test_trigger_timing();
        ranger_cfg_t c;
        c = reset_cfg();
        c.enable     = 1'b1;
        c.period_us  = '0;
        c.trigger_us = '0;
        load_config(c);
        repeat (3) send_tick(2'b00);
        c.period_us  = 20'd3;
        c.trigger_us = '1;
        load_config(c);
        repeat (4) send_tick(2'b11);
        c.period_us  = 20'd1000000;
        c.trigger_us = 8'd1;
        load_config(c);
        repeat (3) send_tick(2'b00);
        c.enable = 1'b0;
        load_config(c);
        repeat (2) send_tick(2'b01);
    endtask

    task automatic test_range_extremes();
        ranger_cfg_t c;
        c = reset_cfg();
        c.range_limit = '0;
        c.margin_one  = -11'sd1024;
        c.margin_two  = 11'sd1023;
        c.spacing     = '1;
        load_config(c);
        send_tick(2'b11);
        send_tick(2'b00);
        c.range_limit = 15'd25600;
        c.margin_one  = 11'sd1023;
        c.margin_two  = -11'sd1024;
        c.spacing     = '0;
        load_config(c);
        send_tick(2'b11);
        send_tick(2'b00);
        c.margin_two = 11'sd1023;
        load_config(c);
        send_tick(2'b11);
        send_tick(2'b00);
        c.margin_one = -11'sd1024;
        c.spacing    = 12'd1;
        load_config(c);
        send_tick(2'b11);
        send_tick(2'b00);
    endtask

    task automatic hold_echo(input int ch, input int ticks);
        logic [1:0] echo;
        for (int n = 0; n <= ticks; n++)
        begin
            echo     = 2'($urandom);
            echo[ch] = (n < ticks);
            send_tick(echo);
        end
    endtask

    task automatic test_long_pulses();
        ranger_cfg_t c;
        c = reset_cfg();
        c.enable      = 1'b1;
        c.period_us   = 20'd50;
        c.trigger_us  = 8'd7;
        c.range_limit = '1;
        c.margin_one  = 11'sd1023;
        c.margin_two  = MARGIN_W'($urandom);
        c.spacing     = SPACING_W'($urandom_range(1, 8));
        load_config(c);
        idle_on = 1'b0;
        hold_echo(0, $urandom_range(250, 350));
        hold_echo(1, $urandom_range(250, 350));
        idle_on = 1'b1;
    endtask

    task automatic test_random_phases();
        ranger_cfg_t c;
        logic [1:0]  level;
        int          left [2];
        bit          noisy;
        level = '0;
        left  = '{0, 0};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            c.enable = ($urandom_range(3) != 0);
            case ($urandom_range(3))
                0:       c.period_us = PERIOD_W'($urandom_range(0, 3));
                1:       c.period_us = PERIOD_W'($urandom_range(4, 40));
                2:       c.period_us = PERIOD_W'($urandom_range(41, 600));
                default: c.period_us = PERIOD_W'($urandom);
            endcase
            c.trigger_us = ($urandom_range(1) == 0) ? TRIG_W'($urandom_range(0, 12))
                                                    : TRIG_W'($urandom);
            case ($urandom_range(2))
                0:       c.range_limit = RANGE_W'($urandom_range(0, 500));
                1:       c.range_limit = RANGE_W'($urandom_range(500, 25600));
                default: c.range_limit = RANGE_W'($urandom);
            endcase
            c.margin_one = MARGIN_W'($urandom);
            c.margin_two = MARGIN_W'($urandom);
            c.spacing    = ($urandom_range(3) == 0) ? SPACING_W'($urandom_range(0, 4))
                                                    : SPACING_W'($urandom);
            if (p == 0)
            begin
                c.enable      = 1'b1;
                c.period_us   = 20'd1;
                c.trigger_us  = 8'd1;
                c.range_limit = '0;
                c.margin_one  = -11'sd1024;
                c.margin_two  = -11'sd1024;
                c.spacing     = 12'd1;
            end
            else if (p == 1)
            begin
                c.enable      = 1'b1;
                c.period_us   = '1;
                c.trigger_us  = '1;
                c.range_limit = '1;
                c.margin_one  = 11'sd1023;
                c.margin_two  = 11'sd1023;
                c.spacing     = '1;
            end
            load_config(c);
            noisy = ($urandom_range(4) == 0);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                for (int ch = 0; ch < 2; ch++)
                begin
                    if (left[ch] == 0)
                    begin
                        level[ch] = !level[ch];
                        left[ch]  = ($urandom_range(7) == 0) ? $urandom_range(60, 400)
                                                             : $urandom_range(1, 24);
                    end
                    left[ch]--;
                end
                send_tick(noisy ? 2'($urandom) : level);
            end
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= !(idle_on && ($urandom_range(99) < 7));

    always @(posedge clk)
    begin : check_results
        ranger_beat_t want;
        ranger_beat_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.level     = m_axis_tdata[0];
            got.dist_one  = m_axis_tdata[DIST_W:1];
            got.dist_two  = m_axis_tdata[2*DIST_W:DIST_W+1];
            got.angle     = m_axis_tdata[2*DIST_W+ANGLE_W:2*DIST_W+1];
            got.valid_one = m_axis_tuser[0];
            got.valid_two = m_axis_tuser[1];
            if (pending_ranges.size() == 0)
                flag_mismatch("result beat with no tick outstanding", 0, 1);
            else
            begin
                want = pending_ranges.pop_front();
                if (got.level !== want.level)
                    flag_mismatch("trigger_level", want.level, got.level);
                if (got.dist_one !== want.dist_one)
                    flag_mismatch("dist_one", want.dist_one, got.dist_one);
                if (got.dist_two !== want.dist_two)
                    flag_mismatch("dist_two", want.dist_two, got.dist_two);
                if (got.angle !== want.angle)
                    flag_mismatch("angle", want.angle, got.angle);
                if (got.valid_one !== want.valid_one)
                    flag_mismatch("valid_one", want.valid_one, got.valid_one);
                if (got.valid_two !== want.valid_two)
                    flag_mismatch("valid_two", want.valid_two, got.valid_two);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        cur_cfg        = reset_cfg();
        period_count   = 0;
        pulse_count    = 0;
        trigger_on     = 1'b0;
        prev_echo      = '0;
        width_running  = '{'0, '0};
        width_captured = '{'0, '0};
        captured_valid = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_trigger_timing();
        test_range_extremes();
        test_long_pulses();
        test_random_phases();
        settle();
        if (mismatch_count == 0 && pending_ranges.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
